// ===== hw/rtl/midi_command_encoder_defines.svh =====
// Assertion macros shared by the MIDI command encoder RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef MIDI_COMMAND_ENCODER_DEFINES_SVH
`define MIDI_COMMAND_ENCODER_DEFINES_SVH

// Same-cycle implication, masked during reset
`define MCE_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("midi command encoder assertion failed");

// Next-cycle implication, masked during reset
`define MCE_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("midi command encoder assertion failed");

`endif

// ===== hw/rtl/mce_pkg.sv =====
// Types and codes for the MIDI command encoder pipeline.
// No dependencies; imported by every stage module and the top level.
`default_nettype none

package mce_pkg;

    // command kinds; codes above KIND_PROGRAM are rejected
    localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_CTRL     = 3'd2;
    localparam logic [2:0] KIND_BEND     = 3'd3;
    localparam logic [2:0] KIND_PN_BEND  = 3'd4;
    localparam logic [2:0] KIND_PROGRAM  = 3'd5;

    // opcode nibbles, shared by packet and byte encodings except OP_PN_BEND (packets only)
    localparam logic [3:0] OP_NOTE_ON  = 4'h9;
    localparam logic [3:0] OP_NOTE_OFF = 4'h8;
    localparam logic [3:0] OP_CTRL     = 4'hB;
    localparam logic [3:0] OP_BEND     = 4'hE;
    localparam logic [3:0] OP_PN_BEND  = 4'h6;
    localparam logic [3:0] OP_PROGRAM  = 4'hC;

    // packet message type: MIDI 2.0 channel voice
    localparam logic [3:0] UMP_MT_CV = 4'h4;

    localparam logic [31:0] BEND_DIV    = 32'h7FFF_FFFF;
    localparam logic [13:0] BEND_CENTER = 14'd8192;

    localparam logic [1:0] CNT_THREE = 2'd3;
    localparam logic [1:0] CNT_TWO   = 2'd2;

    typedef struct packed {
        logic        kind_ok;
        logic        mode2;
        logic [2:0]  kind;
        logic [3:0]  group;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [15:0] vel_hi;
        logic [6:0]  ctrl_number;
        logic [31:0] ctrl_value;
        logic [31:0] bend_off;
    } t_cmd;

    typedef struct packed {
        logic        accepted;
        logic        is_packet;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [7:0]  status;
        logic [6:0]  data_one;
        logic [6:0]  data_two;
        logic [1:0]  byte_count;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/mce_front.sv =====
// Stage 1: input register, kind check and bend magnitude/sign split.
// Depends on mce_pkg.
`default_nettype none

module mce_front import mce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mode2,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_kind,
    input  logic [3:0]         i_group,
    input  logic [3:0]         i_channel,
    input  logic [6:0]         i_note,
    input  logic [31:0]        i_velocity,
    input  logic [6:0]         i_ctrl_number,
    input  logic [31:0]        i_ctrl_value,
    input  logic signed [31:0] i_bend,
    output logic               o_valid,
    input  logic               i_dn_ready,
    output t_cmd               o_cmd,
    output logic [31:0]        o_mag,
    output logic               o_neg
);

    logic        r_v;
    t_cmd        r_cmd;
    logic [31:0] r_mag;
    logic        r_neg;

    t_cmd        n_cmd;
    logic [31:0] n_mag;
    logic [31:0] bend_bits;

    assign bend_bits = unsigned'(i_bend);
    assign o_ready   = !r_v || i_dn_ready;

    always_comb begin
        n_cmd.kind_ok     = (i_kind <= KIND_PROGRAM);
        n_cmd.mode2       = i_mode2;
        n_cmd.kind        = i_kind;
        n_cmd.group       = i_group;
        n_cmd.channel     = i_channel;
        n_cmd.note        = i_note;
        n_cmd.vel_hi      = i_velocity[31:16];
        n_cmd.ctrl_number = i_ctrl_number;
        n_cmd.ctrl_value  = i_ctrl_value;
        // offset-binary bend for the packet word
        n_cmd.bend_off    = {~bend_bits[31], bend_bits[30:0]};
        // most negative value maps to 0x8000_0000, still correct unsigned
        n_mag = bend_bits[31] ? (~bend_bits + 32'd1) : bend_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
            r_mag <= n_mag;
            r_neg <= bend_bits[31];
        end
    end

    assign o_valid = r_v;
    assign o_cmd   = r_cmd;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

`default_nettype wire

// ===== hw/rtl/mce_bend_scale.sv =====
// Stages 2 and 3: scale bend magnitude by 8191/(2^31-1), truncated.
// Uses p = a*2^31 + r, so p / (2^31-1) = a + ((a + r) >= 2^31-1). Depends on mce_pkg.
`default_nettype none

module mce_bend_scale import mce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_mag,
    input  logic        i_neg,
    output logic        o_valid,
    input  logic        i_dn_ready,
    output t_cmd        o_cmd,
    output logic [12:0] o_q,
    output logic        o_neg
);

    logic        r_v2;
    t_cmd        r_cmd2;
    logic [43:0] r_p;
    logic        r_neg2;

    logic        r_v3;
    t_cmd        r_cmd3;
    logic [12:0] r_q;
    logic        r_neg3;

    logic        rdy2;
    logic        rdy3;
    logic [43:0] n_p;
    logic [31:0] fold_sum;
    logic [12:0] n_q;

    assign rdy3    = !r_v3 || i_dn_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // mag * 8191 as (mag << 13) - mag; product stays below 2^44
    assign n_p = {i_mag[30:0], 13'b0} - {12'b0, i_mag};

    always_comb begin
        fold_sum = {19'b0, r_p[43:31]} + {1'b0, r_p[30:0]};
        n_q      = r_p[43:31] + {12'b0, (fold_sum >= BEND_DIV)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_cmd2 <= i_cmd;
            r_p    <= n_p;
            r_neg2 <= i_neg;
        end
        if (rdy3 && r_v2) begin
            r_cmd3 <= r_cmd2;
            r_q    <= n_q;
            r_neg3 <= r_neg2;
        end
    end

    assign o_valid = r_v3;
    assign o_cmd   = r_cmd3;
    assign o_q     = r_q;
    assign o_neg   = r_neg3;

endmodule

`default_nettype wire

// ===== hw/rtl/mce_format.sv =====
// Stage 4: builds the packet words or MIDI 1.0 bytes into the output register.
// Depends on mce_pkg and midi_command_encoder_defines.svh.
`default_nettype none
`include "midi_command_encoder_defines.svh"

module mce_format import mce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic [12:0] i_q,
    input  logic        i_neg,
    output logic        o_valid,
    input  logic        i_dn_ready,
    output t_result     o_res
);

    logic    r_v;
    t_result r_out;
    t_result n_out;

    logic [13:0] pb;
    logic [3:0]  op;
    logic [6:0]  idx;

    assign o_ready = !r_v || i_dn_ready;

    always_comb begin
        pb    = i_neg ? (BEND_CENTER - {1'b0, i_q}) : (BEND_CENTER + {1'b0, i_q});
        n_out = '0;
        op    = OP_PROGRAM;
        idx   = '0;
        if (!i_cmd.kind_ok) begin
            // rejected kind: everything stays zero
            n_out = '0;
        end else if (i_cmd.mode2) begin
            n_out.accepted  = 1'b1;
            n_out.is_packet = 1'b1;
            unique case (i_cmd.kind)
                KIND_NOTE_ON: begin
                    op          = OP_NOTE_ON;
                    idx         = i_cmd.note;
                    n_out.word1 = {i_cmd.vel_hi, 16'h0000};
                end
                KIND_NOTE_OFF: begin
                    op          = OP_NOTE_OFF;
                    idx         = i_cmd.note;
                    n_out.word1 = {i_cmd.vel_hi, 16'h0000};
                end
                KIND_CTRL: begin
                    op          = OP_CTRL;
                    idx         = i_cmd.ctrl_number;
                    n_out.word1 = i_cmd.ctrl_value;
                end
                KIND_BEND: begin
                    op          = OP_BEND;
                    n_out.word1 = i_cmd.bend_off;
                end
                KIND_PN_BEND: begin
                    op          = OP_PN_BEND;
                    idx         = i_cmd.note;
                    n_out.word1 = i_cmd.bend_off;
                end
                default: begin
                    op          = OP_PROGRAM;
                    n_out.word1 = {1'b0, i_cmd.ctrl_number, 24'h000000};
                end
            endcase
            n_out.word0 = {UMP_MT_CV, i_cmd.group, op, i_cmd.channel, 1'b0, idx, 8'h00};
        end else begin
            n_out.accepted   = 1'b1;
            n_out.byte_count = CNT_THREE;
            unique case (i_cmd.kind)
                KIND_NOTE_ON: begin
                    op             = OP_NOTE_ON;
                    n_out.data_one = i_cmd.note;
                    n_out.data_two = i_cmd.vel_hi[15:9];
                end
                KIND_NOTE_OFF: begin
                    op             = OP_NOTE_OFF;
                    n_out.data_one = i_cmd.note;
                    n_out.data_two = i_cmd.vel_hi[15:9];
                end
                KIND_CTRL: begin
                    op             = OP_CTRL;
                    n_out.data_one = i_cmd.ctrl_number;
                    n_out.data_two = i_cmd.ctrl_value[31:25];
                end
                KIND_BEND, KIND_PN_BEND: begin
                    // per-note bend falls back to channel bend
                    op             = OP_BEND;
                    n_out.data_one = pb[6:0];
                    n_out.data_two = pb[13:7];
                end
                default: begin
                    op               = OP_PROGRAM;
                    n_out.data_one   = i_cmd.ctrl_number;
                    n_out.byte_count = CNT_TWO;
                end
            endcase
            n_out.status = {op, i_cmd.channel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v;
    assign o_res   = r_out;

    `MCE_ASSERT_IMP(a_pkt_needs_accept, r_v && r_out.is_packet, r_out.accepted)
    `MCE_ASSERT_IMP(a_reject_is_zero, r_v && !r_out.accepted, r_out == '0)
    `MCE_ASSERT_IMP(a_bytes_clean,
        r_v && r_out.accepted && !r_out.is_packet,
        r_out.word0 == '0 && r_out.word1 == '0 && (r_out.byte_count == CNT_THREE ||
        (r_out.byte_count == CNT_TWO && r_out.data_two == '0)))
    `MCE_ASSERT_IMP(a_pkt_clean, r_v && r_out.is_packet,
        r_out.word0[31:28] == UMP_MT_CV && r_out.status == '0 && r_out.byte_count == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/midi_command_encoder.sv =====
// Top level of the MIDI command encoder: ports, mode register, stage chain.
// Depends on mce_pkg, mce_front, mce_bend_scale and mce_format.
//
//  channel   dir  beat moves          payload
//  s_axis    in   one MIDI command    tuser kind, tdata command fields
//  m_axis    out  one encoded message tuser accepted/is_packet, tdata words/bytes
//  cfg       in   mode register write data bit 0 = midi2_mode
//
// Four register stages: input/magnitude, bend multiply, bend fold, format.
// One command per cycle sustained while m_axis does not stall; each command passes the
// input, bend multiply, bend fold and format registers in turn before its beat leaves.
// Each stage takes a beat when it is empty or its successor moves, so a stall
// on m_axis backs up stage by stage and loses nothing.
// Reset clears all valid bits and sets midi2_mode to 0; cfg is always ready.
`default_nettype none

module midi_command_encoder import mce_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,        // midi2_mode
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // group[3:0] channel[7:4] note[14:8] velocity[46:15] ctrl_number[53:47]
    // ctrl_value[85:54] bend[117:86], zero pad to 120
    input  logic [119:0]  i_s_axis_tdata,
    input  logic [2:0]    i_s_axis_tuser,    // kind[2:0]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // packet_word0[31:0] packet_word1[63:32] status_byte[71:64] data_one[78:72]
    // data_two[85:79] byte_count[87:86]
    output logic [87:0]   o_m_axis_tdata,
    output logic [1:0]    o_m_axis_tuser     // accepted[0] is_packet[1]
);

    logic r_midi2_mode;

    logic        f_valid;
    logic        f_ready;
    t_cmd        f_cmd;
    logic [31:0] f_mag;
    logic        f_neg;

    logic        b_valid;
    logic        b_ready;
    t_cmd        b_cmd;
    logic [12:0] b_q;
    logic        b_neg;

    t_result     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi2_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_midi2_mode <= i_cfg_data;
        end
    end

    mce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode2       (r_midi2_mode),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_kind        (i_s_axis_tuser),
        .i_group       (i_s_axis_tdata[3:0]),
        .i_channel     (i_s_axis_tdata[7:4]),
        .i_note        (i_s_axis_tdata[14:8]),
        .i_velocity    (i_s_axis_tdata[46:15]),
        .i_ctrl_number (i_s_axis_tdata[53:47]),
        .i_ctrl_value  (i_s_axis_tdata[85:54]),
        .i_bend        (signed'(i_s_axis_tdata[117:86])),
        .o_valid       (f_valid),
        .i_dn_ready    (f_ready),
        .o_cmd         (f_cmd),
        .o_mag         (f_mag),
        .o_neg         (f_neg)
    );

    mce_bend_scale u_bend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .o_ready    (f_ready),
        .i_cmd      (f_cmd),
        .i_mag      (f_mag),
        .i_neg      (f_neg),
        .o_valid    (b_valid),
        .i_dn_ready (b_ready),
        .o_cmd      (b_cmd),
        .o_q        (b_q),
        .o_neg      (b_neg)
    );

    mce_format u_format (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (b_valid),
        .o_ready    (b_ready),
        .i_cmd      (b_cmd),
        .i_q        (b_q),
        .i_neg      (b_neg),
        .o_valid    (o_m_axis_tvalid),
        .i_dn_ready (i_m_axis_tready),
        .o_res      (res)
    );

    assign o_m_axis_tdata = {res.byte_count, res.data_two, res.data_one, res.status,
                             res.word1, res.word0};
    assign o_m_axis_tuser = {res.is_packet, res.accepted};

endmodule

`default_nettype wire

// ===== test/tb_midi_command_encoder.sv =====
// Self-checking testbench for midi_command_encoder: streams MIDI commands in both
// encodings and compares every encoded message against a predictor in the scoreboard.
// Depends on mce_pkg and the midi_command_encoder RTL.
`timescale 1ns / 100ps

module tb_midi_command_encoder;
    import mce_pkg::*;

    localparam logic [2:0] KIND_MAX    = 3'd7;
    localparam longint     BEND_SCALE  = 8191;
    localparam int         STALL_LIMIT = 500;
    localparam int         PHASE_ITEMS = 200;
    localparam int         DRAIN_CYCLES = 8;

    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  group;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [31:0] velocity;
        logic [6:0]  ctrl_number;
        logic [31:0] ctrl_value;
        logic [31:0] bend;
    } t_command;

    class midi_scoreboard;
        bit          midi2_mode;
        t_result     expected_msgs[$];
        int unsigned error_count;

        function new();
            midi2_mode  = 1'b0;
            error_count = 0;
        endfunction

        function void set_mode(bit mode);
            midi2_mode = mode;
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction

        function t_result encode_command(t_command c);
            t_result     r;
            logic [3:0]  op;
            logic [6:0]  index;
            logic [13:0] bend14;
            longint      scaled;
            r = '0;
            if (c.kind > KIND_PROGRAM) begin
                return r;
            end
            r.accepted = 1'b1;
            if (midi2_mode) begin
                r.is_packet = 1'b1;
                index = '0;
                case (c.kind)
                    KIND_NOTE_ON, KIND_NOTE_OFF: begin
                        op = (c.kind == KIND_NOTE_ON) ? OP_NOTE_ON : OP_NOTE_OFF;
                        index = c.note;
                        r.word1 = {c.velocity[31:16], 16'h0000};
                    end
                    KIND_CTRL: begin
                        op = OP_CTRL;
                        index = c.ctrl_number;
                        r.word1 = c.ctrl_value;
                    end
                    KIND_BEND, KIND_PN_BEND: begin
                        op = (c.kind == KIND_BEND) ? OP_BEND : OP_PN_BEND;
                        if (c.kind == KIND_PN_BEND) begin
                            index = c.note;
                        end
                        // offset binary: flip the sign bit
                        r.word1 = {~c.bend[31], c.bend[30:0]};
                    end
                    default: begin
                        op = OP_PROGRAM;
                        r.word1 = {1'b0, c.ctrl_number, 24'h000000};
                    end
                endcase
                r.word0 = {UMP_MT_CV, c.group, op, c.channel, 1'b0, index, 8'h00};
            end else begin
                r.byte_count = CNT_THREE;
                case (c.kind)
                    KIND_NOTE_ON, KIND_NOTE_OFF: begin
                        op = (c.kind == KIND_NOTE_ON) ? OP_NOTE_ON : OP_NOTE_OFF;
                        r.data_one = c.note;
                        r.data_two = c.velocity[31:25];
                    end
                    KIND_CTRL: begin
                        op = OP_CTRL;
                        r.data_one = c.ctrl_number;
                        r.data_two = c.ctrl_value[31:25];
                    end
                    KIND_BEND, KIND_PN_BEND: begin
                        // per-note bend falls back to channel bend; division truncates
                        op = OP_BEND;
                        scaled = (longint'($signed(c.bend)) * BEND_SCALE)
                                 / longint'(BEND_DIV);
                        bend14 = 14'(longint'(BEND_CENTER) + scaled);
                        r.data_one = bend14[6:0];
                        r.data_two = bend14[13:7];
                    end
                    default: begin
                        op = OP_PROGRAM;
                        r.data_one = c.ctrl_number;
                        r.byte_count = CNT_TWO;
                    end
                endcase
                r.status = {op, c.channel};
            end
            return r;
        endfunction

        function void note_command(t_command c);
            expected_msgs.push_back(encode_command(c));
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_msgs.size() == 0) begin
                $error("message beat with no command pending");
                error_count++;
                return;
            end
            want = expected_msgs.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
            compare_field("is_packet", 32'(want.is_packet), 32'(got.is_packet));
            compare_field("packet_word0", want.word0, got.word0);
            compare_field("packet_word1", want.word1, got.word1);
            compare_field("status_byte", 32'(want.status), 32'(got.status));
            compare_field("data_one", 32'(want.data_one), 32'(got.data_one));
            compare_field("data_two", 32'(want.data_two), 32'(got.data_two));
            compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_data = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [119:0] i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [87:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    bit idling_on = 1'b1;
    midi_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    midi_command_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_command random_command();
        t_command c;
        if ($urandom_range(0, 11) == 0) begin
            c.kind = 3'($urandom_range(KIND_PROGRAM + 1, KIND_MAX));
        end else begin
            c.kind = 3'($urandom_range(KIND_NOTE_ON, KIND_PROGRAM));
        end
        c.group       = 4'($urandom());
        c.channel     = 4'($urandom());
        c.note        = 7'($urandom());
        c.velocity    = random_word();
        c.ctrl_number = 7'($urandom());
        c.ctrl_value  = random_word();
        c.bend        = random_word();
        return c;
    endfunction

    // hold the beat until the encoder takes it; leave tvalid high for the next one
    task automatic send_command(t_command c);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= c.kind;
        i_s_axis_tdata  <= {2'b00, c.bend, c.ctrl_value, c.ctrl_number, c.velocity,
                            c.note, c.channel, c.group};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_command(c);
    endtask

    task automatic finish_phase();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(bit mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_mode(mode);
    endtask

    task automatic run_directed();
        t_command c;
        for (int i = 0; i < 12; i++) begin
            c = random_command();
            case (i)
                0: begin
                    c.kind = KIND_NOTE_ON; c.group = '0; c.channel = '0;
                    c.note = '0; c.velocity = '0;
                end
                1: begin
                    c.kind = KIND_NOTE_ON; c.group = '1; c.channel = '1;
                    c.note = '1; c.velocity = '1;
                end
                2: begin
                    // smallest velocity that still shows in the top seven bits
                    c.kind = KIND_NOTE_OFF; c.velocity = 32'h0200_0000;
                end
                3: begin
                    c.kind = KIND_CTRL; c.ctrl_number = '1; c.ctrl_value = '1;
                end
                4: begin
                    c.kind = KIND_CTRL; c.ctrl_number = '0; c.ctrl_value = 32'h01FF_FFFF;
                end
                5: begin
                    c.kind = KIND_BEND; c.bend = 32'h8000_0000;
                end
                6: begin
                    c.kind = KIND_BEND; c.bend = 32'h7FFF_FFFF;
                end
                7: begin
                    c.kind = KIND_BEND; c.bend = '0;
                end
                8: begin
                    c.kind = KIND_PN_BEND; c.bend = '1; c.note = '1;
                end
                9: begin
                    c.kind = KIND_PROGRAM; c.ctrl_number = '1;
                end
                10: begin
                    c.kind = KIND_PROGRAM + 3'd1; c.group = '1; c.channel = '1;
                    c.note = '1; c.velocity = '1; c.ctrl_number = '1;
                    c.ctrl_value = '1; c.bend = '1;
                end
                default: begin
                    c.kind = KIND_MAX;
                end
            endcase
            send_command(c);
        end
    endtask

    task automatic run_random(int count);
        repeat (count) send_command(random_command());
    endtask

    // sink side: random stalls while idling is on
    initial begin
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got            = '0;
            got.accepted   = o_m_axis_tuser[0];
            got.is_packet  = o_m_axis_tuser[1];
            got.word0      = o_m_axis_tdata[31:0];
            got.word1      = o_m_axis_tdata[63:32];
            got.status     = o_m_axis_tdata[71:64];
            got.data_one   = o_m_axis_tdata[78:72];
            got.data_two   = o_m_axis_tdata[85:79];
            got.byte_count = o_m_axis_tdata[87:86];
            sb.check_result(got);
        end
    end

    // end the run when no beat moves on any channel for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte encoding straight out of reset, then packets
        run_directed();
        finish_phase();
        write_mode(1'b1);
        run_directed();
        finish_phase();

        write_mode(1'b0);
        run_random(PHASE_ITEMS);
        finish_phase();
        write_mode(1'b1);
        run_random(PHASE_ITEMS);
        finish_phase();
        write_mode(1'b0);
        run_random(PHASE_ITEMS);
        finish_phase();

        // full rate on both sides for the last stretch
        idling_on = 1'b0;
        write_mode(1'b1);
        run_random(PHASE_ITEMS);
        finish_phase();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
